>>> rtl/core/kinetic_scroll_engine_assert.svh
// assertion macros for the kinetic scroll engine checker
`ifndef KINETIC_SCROLL_ENGINE_ASSERT_SVH
`define KINETIC_SCROLL_ENGINE_ASSERT_SVH

// same-cycle implication, quiet while reset is high
`define KSE_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet while reset is high
`define KSE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/kse_pkg.sv
// types, constants and codes for the kinetic scroll engine
package kse_pkg;

   localparam int FRAC_BITS   = 8;
   localparam int DELTA_W     = 24;
   localparam int SPEED_W     = 24;
   localparam int POS_W       = 32;
   localparam int TIME_W      = 16;
   localparam int SPEED_LIM_W = 23;
   localparam int MAG_W       = 22;
   localparam int STEP_W      = FRAC_BITS + 1;
   localparam int CNT_W       = $clog2(FRAC_BITS);

   // divide by five as multiply by a rounded-up reciprocal
   localparam int DIV5_SHIFT  = 25;
   localparam int DIV5_MULT   = (2 ** DIV5_SHIFT + 4) / 5;
   localparam int DIV5_MULT_W = DIV5_SHIFT - 2;
   localparam int PROD_W      = DELTA_W + DIV5_MULT_W;

   localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(1) << FRAC_BITS;
   localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(FRAC_BITS - 1);

   localparam logic [TIME_W-1:0]      TIME_MIN_RESET  = 16'd50;
   localparam logic [TIME_W-1:0]      TIME_MAX_RESET  = 16'd300;
   localparam logic [SPEED_LIM_W-1:0] MAX_SPEED_RESET = 23'd2560;

   localparam logic [1:0] CSR_TIME_MIN  = 2'd0;
   localparam logic [1:0] CSR_TIME_MAX  = 2'd1;
   localparam logic [1:0] CSR_MAX_SPEED = 2'd2;

   localparam logic [1:0] CMD_MOVE    = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_MOVE   = 2'd1,
      MODE_SCROLL = 2'd2
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SPEED,
      ST_MAX,
      ST_DIV_INIT,
      ST_DIV,
      ST_DIV_END,
      ST_SUB,
      ST_FIN
   } state_type;

   typedef enum logic [3:0] {
      LOP_NONE,
      LOP_LOAD,
      LOP_MUL5,
      LOP_SPEED,
      LOP_DIV_INIT,
      LOP_DIV_STEP,
      LOP_DIV_END,
      LOP_LOWER,
      LOP_SUB_DELTA,
      LOP_SUB_SPEED
   } lane_op_type;

   typedef struct packed {
      lane_op_type op;
      logic        div_zero;
   } lane_ctrl_type;

   typedef struct packed {
      logic [MAG_W-1:0] mag;
      logic             speed_zero;
   } lane_stat_type;

   typedef struct packed {
      logic [1:0]                command;
      logic signed [DELTA_W-1:0] delta_x;
      logic signed [DELTA_W-1:0] delta_y;
      logic [TIME_W-1:0]         now_ms;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] offset_x;
      logic signed [POS_W-1:0] offset_y;
      mode_type                mode;
      logic                    ticks_wanted;
   } rsp_type;

endpackage

>>> rtl/core/kse_lane.sv
// one axis lane: speed from delta, step divider, tick slow-down and saturating offset
module kse_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  kse_pkg::lane_ctrl_type              ctrl,
   input  logic signed [kse_pkg::DELTA_W-1:0]  req_delta,
   input  logic [kse_pkg::MAG_W-1:0]           div_max,
   input  logic [kse_pkg::SPEED_LIM_W-1:0]     max_speed,
   output kse_pkg::lane_stat_type              stat,
   output logic signed [kse_pkg::POS_W-1:0]    pos
);
   import kse_pkg::*;

   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic [MAG_W:0]            rem_ff, rem_in;
   logic [STEP_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [POS_W-1:0]   pos_ff, pos_in;

   logic [DELTA_W-1:0]        dmag;
   logic [PROD_W-1:0]         prod;
   logic [MAG_W-1:0]          quot;
   logic [SPEED_W-1:0]        speed_new;
   logic [MAG_W:0]            div_m;
   logic [MAG_W:0]            mag_ext;
   logic [MAG_W:0]            sh;
   logic                      init_ge;
   logic                      step_ge;
   logic signed [SPEED_W:0]   s_ext;
   logic signed [SPEED_W:0]   lim;
   logic signed [SPEED_W:0]   step_ext;
   logic signed [SPEED_W:0]   clamped;
   logic signed [SPEED_W:0]   t;
   logic signed [SPEED_W:0]   lowered;
   logic signed [SPEED_W-1:0] sub_b;
   logic signed [POS_W:0]     diff;
   logic signed [POS_W-1:0]   sat_diff;

   // |delta| / 5 by reciprocal, exact over the whole 24-bit range
   always_comb begin
      dmag      = delta_ff[DELTA_W-1] ? (~delta_ff + 1'b1) : delta_ff;
      prod      = PROD_W'(dmag) * PROD_W'(DIV5_MULT);
      quot      = prod_ff[DIV5_SHIFT +: MAG_W];
      speed_new = neg_ff ? -SPEED_W'(quot) : SPEED_W'(quot);
   end

   // restoring divide, one quotient bit a cycle
   always_comb begin
      div_m   = {1'b0, div_max};
      mag_ext = {1'b0, mag_ff};
      sh      = {rem_ff[MAG_W-1:0], 1'b0};
      init_ge = mag_ext >= div_m;
      step_ge = sh >= div_m;
   end

   // clamp to the speed limit, then move towards zero without crossing it
   always_comb begin
      s_ext    = {speed_ff[SPEED_W-1], speed_ff};
      lim      = {{(SPEED_W + 1 - SPEED_LIM_W){1'b0}}, max_speed};
      step_ext = {{(SPEED_W + 1 - STEP_W){1'b0}}, step_ff};
      if (s_ext > lim) begin
         clamped = lim;
      end else if (s_ext < -lim) begin
         clamped = -lim;
      end else begin
         clamped = s_ext;
      end
      t       = '0;
      lowered = '0;
      if (clamped > 0) begin
         t       = clamped - step_ext;
         lowered = t[SPEED_W] ? '0 : t;
      end else if (clamped < 0) begin
         t       = clamped + step_ext;
         lowered = (t > 0) ? '0 : t;
      end
   end

   always_comb begin
      sub_b = (ctrl.op == LOP_SUB_DELTA) ? delta_ff : speed_ff;
      diff  = {pos_ff[POS_W-1], pos_ff} - {{(POS_W + 1 - SPEED_W){sub_b[SPEED_W-1]}}, sub_b};
      if (diff[POS_W] != diff[POS_W-1]) begin
         sat_diff = diff[POS_W] ? {1'b1, {(POS_W - 1){1'b0}}} : {1'b0, {(POS_W - 1){1'b1}}};
      end else begin
         sat_diff = diff[POS_W-1:0];
      end
   end

   always_comb begin
      delta_in = delta_ff;
      prod_in  = prod_ff;
      neg_in   = neg_ff;
      speed_in = speed_ff;
      mag_in   = mag_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      step_in  = step_ff;
      pos_in   = pos_ff;
      unique case (ctrl.op)
         LOP_LOAD: begin
            delta_in = req_delta;
         end
         LOP_MUL5: begin
            prod_in = prod;
            neg_in  = delta_ff[DELTA_W-1];
         end
         LOP_SPEED: begin
            speed_in = speed_new;
            mag_in   = quot;
         end
         LOP_DIV_INIT: begin
            rem_in = init_ge ? (mag_ext - div_m) : mag_ext;
            quo_in = {{FRAC_BITS{1'b0}}, init_ge};
         end
         LOP_DIV_STEP: begin
            rem_in = step_ge ? (sh - div_m) : sh;
            quo_in = {quo_ff[STEP_W-2:0], step_ge};
         end
         LOP_DIV_END: begin
            // round up so a moving axis never gets a zero step
            step_in = ctrl.div_zero ? STEP_ONE : (quo_ff + STEP_W'(rem_ff != '0));
         end
         LOP_LOWER: begin
            speed_in = lowered[SPEED_W-1:0];
         end
         LOP_SUB_DELTA, LOP_SUB_SPEED: begin
            pos_in = sat_diff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      delta_ff <= delta_in;
      prod_ff  <= prod_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         step_ff  <= STEP_ONE;
         pos_ff   <= '0;
      end else begin
         speed_ff <= speed_in;
         step_ff  <= step_in;
         pos_ff   <= pos_in;
      end
   end

   assign stat.mag        = mag_ff;
   assign stat.speed_zero = (speed_ff == '0);
   assign pos             = pos_ff;

endmodule

>>> rtl/core/kinetic_scroll_engine.sv
// kinetic scroll engine top level: sequencer, lane merge, registers and result stage
//
// A word on the req channel carries a command (move, release or scroll tick),
// a pointer delta per axis and the current time in ms. Each accepted word gives
// exactly one rsp word: both offsets, the mode and whether ticks are wanted.
// Both channels hand over a word when valid is high and stall is low.
// The csr channel writes the minimum and maximum release times and the speed
// limit; csr_ready is always high, unknown indexes are dropped.
// From acceptance to the result register, a move, an ignored command, a
// release that goes idle or a tick outside scroll pass decode and finish;
// a scrolling tick adds the subtract state; a release that starts a scroll
// adds speed, max, divide init, the divide steps and divide end. The step
// divider yields one quotient bit per cycle in each axis lane. One word is
// in flight at a time, so req_stall stays high from acceptance until the
// result is registered; the next word can be taken in the following cycle,
// while the result may still be waiting. A stalled rsp word holds; a finished
// item waits in the sequencer until the result register frees up.
// Reset is synchronous: mode idle, offsets and speeds zero, registers at their
// defaults, no result pending.
module kinetic_scroll_engine (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  kse_pkg::req_type                  req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output kse_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [kse_pkg::SPEED_LIM_W-1:0]   csr_data
);
   import kse_pkg::*;

   state_type               state_ff, state_in;
   mode_type                mode_ff, mode_in;
   logic [TIME_W-1:0]       stamp_ff, stamp_in;
   logic [1:0]              cmd_ff, cmd_in;
   logic [TIME_W-1:0]       now_ff, now_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [MAG_W-1:0]        div_max_ff, div_max_in;
   logic [TIME_W-1:0]       time_min_ff, time_min_in;
   logic [TIME_W-1:0]       time_max_ff, time_max_in;
   logic [SPEED_LIM_W-1:0]  max_speed_ff, max_speed_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;

   lane_ctrl_type           lane_ctrl;
   lane_stat_type           stat_x;
   lane_stat_type           stat_y;
   logic signed [POS_W-1:0] pos_x;
   logic signed [POS_W-1:0] pos_y;
   logic [TIME_W-1:0]       elapsed;
   logic                    in_window;
   logic                    rsp_load;

   kse_lane u_lane_x (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .req_delta (req_data.delta_x),
      .div_max   (div_max_ff),
      .max_speed (max_speed_ff),
      .stat      (stat_x),
      .pos       (pos_x)
   );

   kse_lane u_lane_y (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (lane_ctrl),
      .req_delta (req_data.delta_y),
      .div_max   (div_max_ff),
      .max_speed (max_speed_ff),
      .stat      (stat_y),
      .pos       (pos_y)
   );

   // elapsed time wraps with the ms counter
   assign elapsed   = now_ff - stamp_ff;
   assign in_window = (elapsed > time_min_ff) && (elapsed < time_max_ff);

   assign csr_ready = 1'b1;

   always_comb begin
      time_min_in  = time_min_ff;
      time_max_in  = time_max_ff;
      max_speed_in = max_speed_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TIME_MIN:  time_min_in  = csr_data[TIME_W-1:0];
            CSR_TIME_MAX:  time_max_in  = csr_data[TIME_W-1:0];
            CSR_MAX_SPEED: max_speed_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in           = state_ff;
      mode_in            = mode_ff;
      stamp_in           = stamp_ff;
      cmd_in             = cmd_ff;
      now_in             = now_ff;
      cnt_in             = cnt_ff;
      div_max_in         = div_max_ff;
      lane_ctrl.op       = LOP_NONE;
      lane_ctrl.div_zero = (div_max_ff == '0);
      rsp_load           = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lane_ctrl.op = LOP_LOAD;
               cmd_in       = req_data.command;
               now_in       = req_data.now_ms;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in = ST_FIN;
            case (cmd_ff)
               CMD_MOVE: begin
                  lane_ctrl.op = LOP_SUB_DELTA;
                  if (mode_ff != MODE_MOVE) begin
                     stamp_in = now_ff;
                     mode_in  = MODE_MOVE;
                  end
               end
               CMD_RELEASE: begin
                  if (in_window) begin
                     lane_ctrl.op = LOP_MUL5;
                     state_in     = ST_SPEED;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end
               CMD_TICK: begin
                  if (mode_ff == MODE_SCROLL) begin
                     lane_ctrl.op = LOP_LOWER;
                     state_in     = ST_SUB;
                  end else begin
                     mode_in = MODE_IDLE;
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SPEED: begin
            lane_ctrl.op = LOP_SPEED;
            state_in     = ST_MAX;
         end
         ST_MAX: begin
            // merge: the larger magnitude is the shared divisor
            div_max_in = (stat_x.mag >= stat_y.mag) ? stat_x.mag : stat_y.mag;
            state_in   = ST_DIV_INIT;
         end
         ST_DIV_INIT: begin
            lane_ctrl.op = LOP_DIV_INIT;
            cnt_in       = '0;
            state_in     = ST_DIV;
         end
         ST_DIV: begin
            lane_ctrl.op = LOP_DIV_STEP;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DIV_END;
            end
         end
         ST_DIV_END: begin
            lane_ctrl.op = LOP_DIV_END;
            mode_in      = MODE_SCROLL;
            state_in     = ST_FIN;
         end
         ST_SUB: begin
            lane_ctrl.op = LOP_SUB_SPEED;
            if (stat_x.speed_zero && stat_y.speed_zero) begin
               mode_in = MODE_IDLE;
            end
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.offset_x     = pos_x;
         rsp_data_in.offset_y     = pos_y;
         rsp_data_in.mode         = mode_ff;
         rsp_data_in.ticks_wanted = (mode_ff == MODE_SCROLL);
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_IDLE;
         stamp_ff     <= '0;
         time_min_ff  <= TIME_MIN_RESET;
         time_max_ff  <= TIME_MAX_RESET;
         max_speed_ff <= MAX_SPEED_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         stamp_ff     <= stamp_in;
         time_min_ff  <= time_min_in;
         time_max_ff  <= time_max_in;
         max_speed_ff <= max_speed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      now_ff      <= now_in;
      cnt_ff      <= cnt_in;
      div_max_ff  <= div_max_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/kse_checker.sv
// port-level checker for the kinetic scroll engine, bound to the top level
`include "kinetic_scroll_engine_assert.svh"

module kse_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  kse_pkg::rsp_type                  rsp_data
);
   import kse_pkg::*;

   // a stalled result word stays put
   `KSE_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp word changed while stalled")

   // ticks are wanted exactly while scrolling
   `KSE_ASSERT_IMPL(a_ticks_mode, rsp_valid, rsp_data.ticks_wanted == (rsp_data.mode == MODE_SCROLL), "ticks_wanted disagrees with mode")

   // one word in flight: busy right after acceptance
   `KSE_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "req side not stalled after acceptance")

   // a new result only appears after the sequencer was busy
   `KSE_ASSERT_IMPL(a_rsp_from_busy, $rose(rsp_valid), $past(req_stall), "result without work in flight")

endmodule

bind kinetic_scroll_engine kse_checker u_kse_checker (.*);
